// ----- hdl/tm_pkg.sv -----
// ----------------------------------------------------------------------------
// tm_pkg
// shared types, opcodes and status codes of the tiny machine step core
// ----------------------------------------------------------------------------
package tm_pkg;

	localparam int IMEM_DEPTH_DEF = 1024;
	localparam int DMEM_DEPTH_DEF = 1024;
	localparam int PC_INDEX_DEF   = 7;
	localparam int WORD_W         = 32;
	localparam int INSN_W         = 43;

	// request types
	localparam logic [1:0] REQ_LOAD_I = 2'd0;
	localparam logic [1:0] REQ_LOAD_D = 2'd1;
	localparam logic [1:0] REQ_STEP   = 2'd2;

	// opcodes
	localparam logic [4:0] OP_HALT = 5'd0;
	localparam logic [4:0] OP_IN   = 5'd1;
	localparam logic [4:0] OP_OUT  = 5'd2;
	localparam logic [4:0] OP_ADD  = 5'd3;
	localparam logic [4:0] OP_SUB  = 5'd4;
	localparam logic [4:0] OP_MUL  = 5'd5;
	localparam logic [4:0] OP_DIV  = 5'd6;
	localparam logic [4:0] OP_LD   = 5'd8;
	localparam logic [4:0] OP_ST   = 5'd9;
	localparam logic [4:0] OP_LDA  = 5'd11;
	localparam logic [4:0] OP_LDC  = 5'd12;
	localparam logic [4:0] OP_JLT  = 5'd13;
	localparam logic [4:0] OP_JLE  = 5'd14;
	localparam logic [4:0] OP_JGT  = 5'd15;
	localparam logic [4:0] OP_JGE  = 5'd16;
	localparam logic [4:0] OP_JEQ  = 5'd17;
	localparam logic [4:0] OP_JNE  = 5'd18;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_BAD_PC  = 3'd2;
	localparam logic [2:0] ST_BAD_DA  = 3'd3;
	localparam logic [2:0] ST_DIV0    = 3'd4;
	localparam logic [2:0] ST_ILLEGAL = 3'd5;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_DEC,
		S_RDB,
		S_EXEC,
		S_LDW,
		S_DIV
	} tm_state_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] q;
	} tm_div_res_t;

endpackage

// ----- hdl/tm_ram.sv -----
// ----------------------------------------------------------------------------
// tm_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module tm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/tm_div.sv -----
// ----------------------------------------------------------------------------
// tm_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module tm_div
	import tm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output tm_div_res_t       res
);

	localparam int CW = $clog2(WORD_W) + 1;

	logic [WORD_W-1:0] rem_q, quo_q, den_q;
	logic              neg_q, run_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   rem_sub;
	logic              fits;

	assign rem_sh  = {rem_q, quo_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = !rem_sub[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WORD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a[WORD_W-1] ? (~a + 1'b1) : a;
			den_q <= b[WORD_W-1] ? (~b + 1'b1) : b;
			neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.q    = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ----- hdl/tiny_machine_instruction_step.sv -----
// ----------------------------------------------------------------------------
// tiny_machine_instruction_step
// tiny machine core: register file, instruction and data store in rams
// ----------------------------------------------------------------------------
// usage
//   one command channel: a word is taken when start is high and busy is low.
//   req_type selects load instruction, load data or execute one step.
//   every command gives exactly one result word, shown for one cycle with
//   done high; the receiver cannot stall, so results are never held.
// sequence
//   loads: result in the cycle after accept.
//   steps: fetch, decode, two register-file reads and execute; LD adds a
//   data-store read and DIV waits for its one-bit-per-cycle divider; a bad
//   pc ends in fetch, halt and an illegal opcode in decode. busy stays
//   high until the result is out, so one command is in work at a time.
//   the single read port of the register-file ram sets the step length.
// reset
//   arst_n clears control state, then a clearing pass over
//   max(IMEM_DEPTH, DMEM_DEPTH, 8) addresses zeroes all three rams; busy is
//   high during the pass.
// ----------------------------------------------------------------------------
module tiny_machine_instruction_step
	import tm_pkg::*;
#(
	parameter int IMEM_DEPTH = IMEM_DEPTH_DEF,
	parameter int DMEM_DEPTH = DMEM_DEPTH_DEF,
	parameter int PC_INDEX   = PC_INDEX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [9:0]         address,
	input  logic [4:0]         opcode,
	input  logic [2:0]         arg_r,
	input  logic signed [31:0] arg_mid,
	input  logic [2:0]         arg_base,
	input  logic signed [31:0] data_value,
	output logic               done,
	output logic [2:0]         status,
	output logic               out_valid,
	output logic signed [31:0] out_value,
	output logic signed [31:0] pc_value
);

	localparam int IAW   = $clog2(IMEM_DEPTH);
	localparam int DAW   = $clog2(DMEM_DEPTH);
	localparam int CLR_A = (IMEM_DEPTH > DMEM_DEPTH) ? IMEM_DEPTH : DMEM_DEPTH;
	localparam int CLR_N = (CLR_A > 8) ? CLR_A : 8;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [2:0] PC_IDX = 3'(PC_INDEX);

	tm_state_t state_q, state_nx;

	logic [CW-1:0]     clr_cnt_q;
	logic [WORD_W-1:0] pc_q;
	logic [WORD_W-1:0] dval_q;
	logic [WORD_W-1:0] a_q;
	logic [4:0]        op_q;
	logic [2:0]        ra_q, rb_q;
	logic [WORD_W-1:0] mid_q;

	// result registers
	logic              done_q, ov_q;
	logic [2:0]        status_q;
	logic [WORD_W-1:0] oval_q, pcv_q;

	// ram ports
	logic              im_we, dm_we, rf_we;
	logic [IAW-1:0]    im_wa, im_ra;
	logic [DAW-1:0]    dm_wa, dm_ra;
	logic [2:0]        rf_wa, rf_ra;
	logic [INSN_W-1:0] im_wd, im_rd;
	logic [WORD_W-1:0] dm_wd, dm_rd, rf_wd, rf_rd;

	// finish signals
	logic              fin, fin_ov;
	logic [2:0]        fin_st;
	logic [WORD_W-1:0] fin_oval;
	logic [WORD_W-1:0] pc_nx;

	logic              accept, clearing;
	logic [WORD_W-1:0] addr32;
	logic [WORD_W-1:0] eff;
	logic              eff_bad;
	logic              take;
	logic              div_start;
	tm_div_res_t       div_res;

	// decode view of the fetched word
	logic [4:0] d_op;
	logic [2:0] d_ra, d_rb;
	logic [2:0] d_s;

	assign accept   = start && !busy;
	assign clearing = (state_q == S_CLEAR);
	assign addr32   = {22'd0, address};
	assign busy     = (state_q != S_IDLE);

	assign d_op = im_rd[42:38];
	assign d_ra = im_rd[37:35];
	assign d_s  = im_rd[5:3];
	assign d_rb = im_rd[2:0];

	// effective address for memory, lda and jump ops
	assign eff     = mid_q + a_q;
	assign eff_bad = (eff >= 32'(DMEM_DEPTH));

	always_comb begin
		case (op_q)
			OP_JLT:  take = rf_rd[31];
			OP_JLE:  take = rf_rd[31] || (rf_rd == '0);
			OP_JGT:  take = !rf_rd[31] && (rf_rd != '0);
			OP_JGE:  take = !rf_rd[31];
			OP_JEQ:  take = (rf_rd == '0);
			OP_JNE:  take = (rf_rd != '0);
			default: take = 1'b0;
		endcase
	end

	// instruction store write port: clearing pass or instruction load
	always_comb begin
		im_we = 1'b0;
		im_wa = addr32[IAW-1:0];
		im_wd = {opcode, arg_r, arg_mid, arg_base};
		if (clearing) begin
			im_we = 1'b1;
			im_wa = clr_cnt_q[IAW-1:0];
			im_wd = '0;
		end else if (accept && req_type == REQ_LOAD_I && addr32 < 32'(IMEM_DEPTH)) begin
			im_we = 1'b1;
		end
	end
	assign im_ra = pc_q[IAW-1:0];

	// data store write port: clearing pass, data load or store op
	always_comb begin
		dm_we = 1'b0;
		dm_wa = addr32[DAW-1:0];
		dm_wd = data_value;
		if (clearing) begin
			dm_we = 1'b1;
			dm_wa = clr_cnt_q[DAW-1:0];
			dm_wd = '0;
		end else if (accept && req_type == REQ_LOAD_D && addr32 < 32'(DMEM_DEPTH)) begin
			dm_we = 1'b1;
		end else if (state_q == S_EXEC && op_q == OP_ST && !eff_bad) begin
			dm_we = 1'b1;
			dm_wa = eff[DAW-1:0];
			dm_wd = rf_rd;
		end
	end
	assign dm_ra = eff[DAW-1:0];

	// register file read address: operand a in decode, operand b after it
	always_comb begin
		case (state_q)
			S_DEC:   rf_ra = (d_op inside {[OP_HALT:OP_DIV]}) ? d_s : d_rb;
			default: rf_ra = (op_q inside {[OP_ADD:OP_DIV]}) ? rb_q : ra_q;
		endcase
	end

	// sequencer: next state, register-file write and result
	always_comb begin
		state_nx  = state_q;
		rf_we     = 1'b0;
		rf_wa     = ra_q;
		rf_wd     = '0;
		fin       = 1'b0;
		fin_st    = ST_OK;
		fin_ov    = 1'b0;
		fin_oval  = '0;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				rf_we = 1'b1;
				rf_wa = clr_cnt_q[2:0];
				if (clr_cnt_q == CW'(CLR_N - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_STEP) begin
						state_nx = S_FETCH;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_FETCH: begin
				if (pc_q >= 32'(IMEM_DEPTH)) begin
					fin      = 1'b1;
					fin_st   = ST_BAD_PC;
					state_nx = S_IDLE;
				end else begin
					// pc moves on before the word is looked at
					rf_we    = 1'b1;
					rf_wa    = PC_IDX;
					rf_wd    = pc_q + 1'b1;
					state_nx = S_DEC;
				end
			end
			S_DEC: begin
				if (d_op == OP_HALT) begin
					fin      = 1'b1;
					fin_st   = ST_HALT;
					state_nx = S_IDLE;
				end else if (!(d_op inside {[OP_IN:OP_DIV], OP_LD, OP_ST,
						[OP_LDA:OP_JNE]})) begin
					fin      = 1'b1;
					fin_st   = ST_ILLEGAL;
					state_nx = S_IDLE;
				end else begin
					state_nx = S_RDB;
				end
			end
			S_RDB: begin
				state_nx = S_EXEC;
			end
			S_EXEC: begin
				state_nx = S_IDLE;
				fin      = 1'b1;
				case (op_q)
					OP_IN: begin
						rf_we = 1'b1;
						rf_wd = dval_q;
					end
					OP_OUT: begin
						fin_ov   = 1'b1;
						fin_oval = rf_rd;
					end
					OP_ADD: begin
						rf_we = 1'b1;
						rf_wd = a_q + rf_rd;
					end
					OP_SUB: begin
						rf_we = 1'b1;
						rf_wd = a_q - rf_rd;
					end
					OP_MUL: begin
						rf_we = 1'b1;
						rf_wd = a_q * rf_rd;
					end
					OP_DIV: begin
						if (rf_rd == '0) begin
							fin_st = ST_DIV0;
						end else begin
							fin       = 1'b0;
							div_start = 1'b1;
							state_nx  = S_DIV;
						end
					end
					OP_LD: begin
						if (eff_bad) begin
							fin_st = ST_BAD_DA;
						end else begin
							fin      = 1'b0;
							state_nx = S_LDW;
						end
					end
					OP_ST: begin
						if (eff_bad) begin
							fin_st = ST_BAD_DA;
						end
					end
					OP_LDA: begin
						rf_we = 1'b1;
						rf_wd = eff;
					end
					OP_LDC: begin
						rf_we = 1'b1;
						rf_wd = mid_q;
					end
					default: begin
						// conditional jumps
						if (take) begin
							rf_we = 1'b1;
							rf_wa = PC_IDX;
							rf_wd = eff;
						end
					end
				endcase
			end
			S_LDW: begin
				rf_we    = 1'b1;
				rf_wd    = dm_rd;
				fin      = 1'b1;
				state_nx = S_IDLE;
			end
			S_DIV: begin
				if (div_res.done) begin
					rf_we    = 1'b1;
					rf_wd    = div_res.q;
					fin      = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// a write to the pc register replaces the shadow copy
	assign pc_nx = (rf_we && !clearing && rf_wa == PC_IDX) ? rf_wd : pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			pc_q      <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			pc_q    <= pc_nx;
			done_q  <= fin;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dval_q <= data_value;
		end
		if (state_q == S_DEC) begin
			op_q  <= d_op;
			ra_q  <= d_ra;
			mid_q <= im_rd[37-3:3];
			rb_q  <= d_rb;
		end
		if (state_q == S_RDB) begin
			a_q <= rf_rd;
		end
		if (fin) begin
			status_q <= fin_st;
			ov_q     <= fin_ov;
			oval_q   <= fin_oval;
			pcv_q    <= pc_nx;
		end
	end

	tm_ram #(.WIDTH(INSN_W), .DEPTH(IMEM_DEPTH)) u_imem (
		.clk   (clk),
		.we    (im_we),
		.waddr (im_wa),
		.wdata (im_wd),
		.raddr (im_ra),
		.rdata (im_rd)
	);

	tm_ram #(.WIDTH(WORD_W), .DEPTH(DMEM_DEPTH)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_wa),
		.wdata (dm_wd),
		.raddr (dm_ra),
		.rdata (dm_rd)
	);

	tm_ram #(.WIDTH(WORD_W), .DEPTH(8)) u_regs (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_wa),
		.wdata (rf_wd),
		.raddr (rf_ra),
		.rdata (rf_rd)
	);

	tm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (a_q),
		.b      (rf_rd),
		.res    (div_res)
	);

	assign done      = done_q;
	assign status    = status_q;
	assign out_valid = ov_q;
	assign out_value = oval_q;
	assign pc_value  = pcv_q;

	// a result word only appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result word while sequencer busy");

	// a bad pc leaves the pc untouched
	a_bad_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_BAD_PC |-> pcv_q == pc_q)
		else $error("pc changed on bad pc");

	// an out word always comes with ok status
	a_out_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && ov_q |-> status_q == ST_OK)
		else $error("out word with error status");

	// the divider only finishes while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider done outside divide wait");

endmodule

// ----- bench/tb_tiny_machine_instruction_step.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiny_machine_instruction_step
// checks the tiny machine step core against a cycle-free software model of
// its registers, instruction store and data store. crafted programs are
// written one instruction at a time at the current pc and then stepped; the
// directed sub into the pc register already leaves the pc out of range.
// ----------------------------------------------------------------------------
module tb_tiny_machine_instruction_step;
	import tm_pkg::*;

	localparam int IDEPTH    = 1024;
	localparam int DDEPTH    = 1024;
	localparam int PCR       = 7;
	localparam int RAND_WORDS = 1520;
	localparam int QUIET_TAIL = 200;       // last words sent back to back
	localparam int LIMIT     = 600000;     // cycles, several times the slowest run

	localparam logic [4:0] OP_RR_LIM = 5'd7;
	localparam logic [4:0] OP_RM_LIM = 5'd10;
	localparam logic [4:0] OP_RA_LIM = 5'd19;

	typedef struct {
		logic [4:0]  op;
		logic [2:0]  ra;
		logic [31:0] mid;
		logic [2:0]  rb;
	} insn_t;

	typedef struct {
		logic [2:0]  st;
		logic        ov;
		logic [31:0] oval;
		logic [31:0] pc;
	} tm_result_t;

	// model of the machine plus the list of answers still to come
	class tm_scoreboard;
		logic [31:0] regs [8];
		insn_t       imem [IDEPTH];
		logic [31:0] dmem [DDEPTH];
		tm_result_t  due [$];
		int          fails;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (imem[i]) imem[i] = '{OP_HALT, 3'd0, 32'd0, 3'd0};
			foreach (dmem[i]) dmem[i] = '0;
			fails = 0;
		endfunction

		// runs one fetched instruction on a register set; pc already known valid
		function void execute(input insn_t w, input logic [31:0] dval,
				inout logic [31:0] rf [8], output logic [2:0] st,
				output logic ov, output logic [31:0] oval,
				output logic wr_en, output logic [9:0] wr_addr);
			logic [31:0] a, b, ma, mb, q, m, v;
			logic take;
			st = ST_OK; ov = 1'b0; oval = '0; wr_en = 1'b0; wr_addr = '0;
			take = 1'b0;
			rf[PCR] = rf[PCR] + 1;
			m = w.mid + rf[w.rb];
			v = rf[w.ra];
			if (w.op <= OP_DIV) begin
				a = rf[w.mid[2:0]];
				b = rf[w.rb];
				case (w.op)
					OP_HALT: st = ST_HALT;
					OP_IN:   rf[w.ra] = dval;
					OP_OUT: begin
						ov = 1'b1;
						oval = v;
					end
					OP_ADD:  rf[w.ra] = a + b;
					OP_SUB:  rf[w.ra] = a - b;
					OP_MUL:  rf[w.ra] = a * b;
					default: begin
						if (b == 0) st = ST_DIV0;
						else begin
							// truncating signed divide; min / -1 wraps to min
							ma = a[31] ? -a : a;
							mb = b[31] ? -b : b;
							q = ma / mb;
							rf[w.ra] = (a[31] != b[31]) ? -q : q;
						end
					end
				endcase
			end else if (w.op == OP_LD || w.op == OP_ST) begin
				if (m >= DDEPTH) st = ST_BAD_DA;
				else if (w.op == OP_LD) rf[w.ra] = dmem[m[9:0]];
				else begin
					wr_en = 1'b1;
					wr_addr = m[9:0];
				end
			end else if (w.op >= OP_LDA && w.op <= OP_JNE) begin
				case (w.op)
					OP_LDA: rf[w.ra] = m;
					OP_LDC: rf[w.ra] = w.mid;
					OP_JLT: take = v[31];
					OP_JLE: take = v[31] || v == 0;
					OP_JGT: take = !v[31] && v != 0;
					OP_JGE: take = !v[31];
					OP_JEQ: take = v == 0;
					default: take = v != 0;
				endcase
				if (take) rf[PCR] = m;
			end else begin
				st = ST_ILLEGAL;
			end
		endfunction

		// true if running w at the current pc leaves the pc inside the store
		function bit pc_stays_ok(insn_t w, logic [31:0] dval);
			logic [31:0] rf [8];
			logic [2:0] st;
			logic ov, we;
			logic [31:0] oval;
			logic [9:0] wa;
			rf = regs;
			execute(w, dval, rf, st, ov, oval, we, wa);
			return rf[PCR] < IDEPTH;
		endfunction

		function void note_word(logic [1:0] req, logic [9:0] addr, insn_t w,
				logic [31:0] dval);
			tm_result_t r;
			insn_t fi;
			logic we;
			logic [9:0] wa;
			r = '{ST_OK, 1'b0, 32'd0, 32'd0};
			if (req == REQ_LOAD_I) imem[addr] = w;
			else if (req == REQ_LOAD_D) dmem[addr] = dval;
			else if (req == REQ_STEP) begin
				if (regs[PCR] >= IDEPTH) r.st = ST_BAD_PC;
				else begin
					fi = imem[regs[PCR][9:0]];
					execute(fi, dval, regs, r.st, r.ov, r.oval, we, wa);
					if (we) dmem[wa] = regs[fi.ra];
				end
			end
			r.pc = regs[PCR];
			due.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic ov, logic [31:0] oval,
				logic [31:0] pc);
			tm_result_t e;
			if (due.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				fails++;
				return;
			end
			e = due.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				fails++;
			end
			if (ov !== e.ov) begin
				$display("%0t: out_valid expected %0b actual %0b", $time, e.ov, ov);
				fails++;
			end
			if (oval !== e.oval) begin
				$display("%0t: out_value expected %h actual %h", $time, e.oval, oval);
				fails++;
			end
			if (pc !== e.pc) begin
				$display("%0t: pc_value expected %h actual %h", $time, e.pc, pc);
				fails++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic [9:0]         address;
	logic [4:0]         opcode;
	logic [2:0]         arg_r;
	logic signed [31:0] arg_mid;
	logic [2:0]         arg_base;
	logic signed [31:0] data_value;
	logic               done;
	logic [2:0]         status;
	logic               out_valid;
	logic signed [31:0] out_value;
	logic signed [31:0] pc_value;

	tm_scoreboard sb;
	int  cycles;
	bit  gaps_on;

	tiny_machine_instruction_step u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .address(address), .opcode(opcode), .arg_r(arg_r),
		.arg_mid(arg_mid), .arg_base(arg_base), .data_value(data_value),
		.done(done), .status(status), .out_valid(out_valid),
		.out_value(out_value), .pc_value(pc_value)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// watchdog, also covers the clearing pass after reset
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result words are only ever shown for one cycle, check each on its edge
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, out_valid, out_value, pc_value);
	end

	// hand one command word over; fields change on the falling edge and the
	// word counts as taken on the rising edge where busy is low
	task automatic send_word(logic [1:0] req, logic [9:0] addr, insn_t w,
			logic [31:0] dval);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_type = req;
		address = addr;
		opcode = w.op;
		arg_r = w.ra;
		arg_mid = w.mid;
		arg_base = w.rb;
		data_value = dval;
		start = 1'b1;
		do @(posedge clk); while (busy);
		sb.note_word(req, addr, w, dval);
	endtask

	// write an instruction at the current pc, then step it
	task automatic run_insn(insn_t w, logic [31:0] dval);
		send_word(REQ_LOAD_I, sb.regs[PCR][9:0], w, $urandom);
		send_word(REQ_STEP, 10'($urandom), '{5'($urandom), 3'($urandom), $urandom,
			3'($urandom)}, dval);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 1100);
			default: return $urandom;
		endcase
	endfunction

	// random instruction, weighted toward memory and jump targets in range
	function automatic insn_t pick_insn();
		insn_t w;
		w.op = 5'($urandom_range(0, 19));
		if (w.op == OP_HALT && $urandom_range(0, 2) != 0) w.op = OP_ADD;
		w.ra = 3'($urandom);
		w.rb = 3'($urandom);
		if ($urandom_range(0, 3) == 0) w.rb = 3'd0;
		if (w.op <= OP_DIV || w.op == OP_LDC) w.mid = pick_value();
		else if ($urandom_range(0, 4) == 0) w.mid = $urandom;
		else w.mid = $urandom_range(0, 1100) - (($urandom_range(0, 5) == 0) ? 80 : 0);
		return w;
	endfunction

	function automatic insn_t mk(logic [4:0] op, logic [2:0] ra, logic [31:0] mid,
			logic [2:0] rb);
		insn_t w;
		w = '{op, ra, mid, rb};
		return w;
	endfunction

	initial begin
		insn_t w;
		logic [31:0] dv;
		int n, tries;

		sb = new();
		cycles = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_LOAD_I;
		address = '0;
		opcode = OP_HALT;
		arg_r = '0;
		arg_mid = '0;
		arg_base = '0;
		data_value = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: halt from the cleared store, then a step word for each operation
		send_word(REQ_STEP, 10'd0, mk(OP_HALT, 0, 0, 0), 32'd0);
		send_word(REQ_LOAD_D, 10'd1023, mk(OP_HALT, 0, 0, 0), 32'h8000_0000);
		send_word(REQ_LOAD_D, 10'd0, mk(OP_HALT, 0, 0, 0), 32'h7fff_ffff);
		run_insn(mk(OP_IN, 1, 0, 0), 32'h7fff_ffff);
		run_insn(mk(OP_IN, 2, 0, 0), 32'h8000_0000);
		run_insn(mk(OP_IN, 3, 0, 0), 32'hffff_ffff);
		run_insn(mk(OP_OUT, 2, 0, 0), 32'd0);
		run_insn(mk(OP_ADD, 4, 32'hffff_fff9, 1), 32'd0);   // high mid bits ignored
		run_insn(mk(OP_MUL, 5, 1, 1), 32'd0);
		run_insn(mk(OP_DIV, 6, 2, 3), 32'd0);               // min / -1 overflow
		run_insn(mk(OP_DIV, 6, 1, 0), 32'd0);               // divide by zero
		run_insn(mk(OP_RR_LIM, 1, 0, 0), 32'd0);
		run_insn(mk(OP_RM_LIM, 1, 32'hffff_ffff, 0), 32'd0);
		run_insn(mk(OP_RA_LIM, 1, 0, 0), 32'd0);
		run_insn(mk(OP_LD, 6, 32'hffff_ffff, 0), 32'd0);    // negative address
		run_insn(mk(OP_ST, 1, 32'd1024, 0), 32'd0);         // one past the end
		run_insn(mk(OP_ST, 1, 32'd1023, 0), 32'd0);
		run_insn(mk(OP_LD, 6, 32'd1023, 0), 32'd0);
		run_insn(mk(OP_SUB, 7, 1, 0), 32'd0);               // result replaces pc
		run_insn(mk(OP_LDA, 6, 32'd40, 0), 32'd0);
		run_insn(mk(OP_JLT, 2, 32'd100, 0), 32'd0);
		run_insn(mk(OP_JLE, 0, 32'd200, 0), 32'd0);
		run_insn(mk(OP_JGT, 1, 32'd300, 0), 32'd0);
		run_insn(mk(OP_JGE, 2, 32'd5, 0), 32'd0);           // not taken
		run_insn(mk(OP_JEQ, 0, 32'd1023, 0), 32'd0);
		run_insn(mk(OP_LDC, 0, 32'd4, 0), 32'd0);           // pc is out of range by now, so this step ends in bad pc
		run_insn(mk(OP_JNE, 0, 32'hffff_fffc, 0), 32'd0);

		// random: mostly crafted programs, some stray loads
		n = 0;
		while (n < RAND_WORDS) begin
			if (n >= RAND_WORDS - QUIET_TAIL) gaps_on = 1'b0;
			dv = pick_value();
			case ($urandom_range(0, 9))
				0, 1: begin
					send_word(REQ_LOAD_D, 10'($urandom), mk(OP_HALT, 0, 0, 0), dv);
					n++;
				end
				2: begin
					w = mk(5'($urandom_range(0, 19)), 3'($urandom), $urandom,
						3'($urandom));
					send_word(REQ_LOAD_I, 10'($urandom), w, $urandom);
					n++;
				end
				3: begin
					if (sb.pc_stays_ok(sb.imem[sb.regs[PCR][9:0]], dv)) begin
						send_word(REQ_STEP, 10'($urandom), pick_insn(), dv);
						n++;
					end
				end
				default: begin
					tries = 0;
					do begin
						w = pick_insn();
						tries++;
					end while (!sb.pc_stays_ok(w, dv) && tries < 20);
					if (!sb.pc_stays_ok(w, dv)) w = mk(OP_LDC, 7, 32'd0, 0);
					run_insn(w, dv);
					n += 2;
				end
			endcase
		end

		// bad pc last: once out of range no step can bring it back
		run_insn(mk(OP_LDC, 7, 32'd1024, 0), 32'd0);
		send_word(REQ_STEP, 10'd0, mk(OP_HALT, 0, 0, 0), 32'd0);
		run_insn(mk(OP_LDC, 7, 32'd0, 0), 32'd0);
		@(negedge clk);
		start = 1'b0;

		while (sb.due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.fails == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/tm_pkg.sv
hdl/tm_ram.sv
hdl/tm_div.sv
hdl/tiny_machine_instruction_step.sv
bench/tb_tiny_machine_instruction_step.sv
